@@ hw/rtl/assert_macros.svh @@
// Assertion macros included by the noise core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: lbl");

// Next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: lbl");

`endif

@@ hw/rtl/gn2d_pkg.sv @@
// Package of constants, stage types and the permutation table for the noise core
package gn2d_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int DIV_W       = COORD_BITS + FRAC_BITS;
  localparam int DIV_STEPS   = DIV_W;
  localparam int SUM_W       = 9;
  localparam int MOD_STEPS   = SUM_W;

  localparam logic [12:0] GRID_RESET    = 13'd200;
  localparam logic [9:0]  ENTRIES_RESET = 10'd512;

  // Register indexes on the configuration port
  localparam logic [0:0] REG_GRID    = 1'b0;
  localparam logic [0:0] REG_ENTRIES = 1'b1;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Divider stage: remainder and shifting dividend/quotient per axis
  typedef struct packed {
    logic        vld;
    logic        op;
    logic [8:0]  ent;
    logic [31:0] gd;
    logic [12:0] rx;
    logic [12:0] ry;
    logic [DIV_W-1:0] nx;
    logic [DIV_W-1:0] ny;
  } dv_t;

  // Modulo stage: four corner indexes reduced by the entry count
  typedef struct packed {
    logic        vld;
    logic        op;
    logic [8:0]  ent;
    logic [31:0] gd;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [3:0][ADDR_W-1:0] mr;
    logic [3:0][SUM_W-1:0]  mn;
  } md_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

endpackage

@@ hw/rtl/gradient_noise_2d_core.sv @@
// Top level of the 2D gradient noise core: divider, modulo, table and blend pipeline
//
// Usage: the in_ channel takes one item a cycle while in_ready is high. op 0
// writes grad_x/grad_y into gradient entry entry_index and gives no result;
// op 1 evaluates noise at (pixel_x, pixel_y) and gives one out_noise_value,
// signed Q1.15, saturated. Items flow in order through a 32-step restoring
// divider (cell and fraction), a 9-step modulo by the entry count, four copies
// of the gradient table (one read port per corner) and a multiplier pipeline
// for dot products, fade and blending. A table write takes effect at the table
// stage, so it is seen by every later pixel and by no earlier one.
// Throughput: one item per cycle while in_ready is high, set by the divider's
// one step per stage and the single read port of each table copy.
// Configuration: grid_size at byte address 0, gradient_entries at 4, written
// through the APB port while no item is in flight.
// Reset clears valid state and the registers to 200 and 512; table contents
// are undefined until written.
// Stall: a held out_valid parks at most one more result in a skid register;
// the pipeline and in_ready then hold until out_ready returns.
`include "assert_macros.svh"

module gradient_noise_2d_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [8:0]         in_entry_index,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic [15:0]        in_pixel_x,
  input  logic [15:0]        in_pixel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_noise_value,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gn2d_pkg::*;

  // Configuration registers
  logic [12:0] grid_size_r;
  logic [9:0]  entries_r;
  logic [0:0]  cfg_idx;
  logic [12:0] grid_eff;
  logic [9:0]  mod_eff;

  // Pipeline control
  logic        en;
  logic        res_vld;
  logic signed [15:0] res_val;
  logic        out_vld_r, sk_vld_r;
  logic signed [15:0] out_val_r, sk_val_r;

  // Stage registers
  dv_t dv_r [DIV_STEPS+1];
  md_t md_r [MOD_STEPS+1];
  logic [31:0] gt_mem [4][TABLE_DEPTH];
  logic [31:0] rd_r [4];
  logic        q1_vld_r;
  logic [FRAC_BITS-1:0] q1_f_r [2];
  logic        q2_vld_r;
  logic signed [32:0] pa_r [4];
  logic signed [32:0] pb_r [4];
  logic signed [37:0] f1_r [2];
  logic [31:0] f2_r [2];
  logic [FRAC_BITS-1:0] q2_f_r [2];
  logic        q3_vld_r;
  logic signed [17:0] dot_r [4];
  logic signed [21:0] poly_r [2];
  logic [31:0] f3_r [2];
  logic        q4_vld_r;
  logic signed [18:0] dd_r [2];
  logic signed [17:0] base_r [2];
  logic signed [38:0] f4_r [2];
  logic        q5_vld_r;
  logic signed [36:0] mx_r [2];
  logic signed [17:0] b5_r [2];
  logic signed [17:0] ey5_r;
  logic        q6_vld_r;
  logic signed [21:0] ab_r [2];
  logic signed [17:0] ey6_r;
  logic        q7_vld_r;
  logic signed [40:0] m7_r;
  logic signed [21:0] a7_r;

  // Combinational helpers
  logic [7:0]  cx, cy, cx1, cy1, pc, pc1;
  logic [31:0] gw;
  logic        gwe;
  logic signed [16:0] dxs [4];
  logic signed [16:0] dys [4];
  logic signed [20:0] inner [2];
  logic signed [17:0] ex4, ey4;
  logic signed [25:0] r_full;

  // One restoring step of the cell/fraction divider on both axes
  function automatic dv_t div_step(dv_t s, logic [12:0] g);
    dv_t o;
    logic [13:0] tx, ty;
    o  = s;
    tx = {s.rx, s.nx[DIV_W-1]};
    ty = {s.ry, s.ny[DIV_W-1]};
    if (tx >= {1'b0, g}) begin
      o.rx = 13'(tx - {1'b0, g});
      o.nx = {s.nx[DIV_W-2:0], 1'b1};
    end else begin
      o.rx = tx[12:0];
      o.nx = {s.nx[DIV_W-2:0], 1'b0};
    end
    if (ty >= {1'b0, g}) begin
      o.ry = 13'(ty - {1'b0, g});
      o.ny = {s.ny[DIV_W-2:0], 1'b1};
    end else begin
      o.ry = ty[12:0];
      o.ny = {s.ny[DIV_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // One restoring step of the corner index modulo on all four corners
  function automatic md_t mod_step(md_t s, logic [9:0] m);
    md_t o;
    logic [9:0] t;
    o = s;
    for (int k = 0; k < 4; k++) begin
      t = {s.mr[k], s.mn[k][SUM_W-1]};
      if (t >= m) begin
        o.mr[k] = ADDR_W'(t - m);
        o.mn[k] = {s.mn[k][SUM_W-2:0], 1'b1};
      end else begin
        o.mr[k] = t[ADDR_W-1:0];
        o.mn[k] = {s.mn[k][SUM_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_RESET;
      entries_r   <= ENTRIES_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_GRID:    grid_size_r <= pwdata[12:0];
        REG_ENTRIES: entries_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GRID:    prdata = {19'd0, grid_size_r};
      REG_ENTRIES: prdata = {22'd0, entries_r};
      default:     prdata = 32'd0;
    endcase
  end

  // Clamp the divisors
  assign grid_eff = (grid_size_r == 13'd0) ? 13'd1 : grid_size_r;
  assign mod_eff  = (entries_r == 10'd0) ? 10'd1 :
                    (entries_r > 10'(TABLE_DEPTH)) ? 10'(TABLE_DEPTH) : entries_r;

  // Advance the whole pipeline unless the skid register is occupied
  assign en       = !sk_vld_r;
  assign in_ready = en;

  // Cell indexes and permutation lookup for the corner sums
  always_comb begin
    cx  = dv_r[DIV_STEPS].nx[FRAC_BITS +: 8];
    cy  = dv_r[DIV_STEPS].ny[FRAC_BITS +: 8];
    cx1 = cx + 8'd1;
    cy1 = cy + 8'd1;
    pc  = PERM[cy];
    pc1 = PERM[cy1];
  end

  // Divider and modulo stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STEPS; s++) dv_r[s].vld <= 1'b0;
      for (int s = 0; s <= MOD_STEPS; s++) md_r[s].vld <= 1'b0;
    end else if (en) begin
      dv_r[0].vld <= in_valid;
      dv_r[0].op  <= in_op;
      dv_r[0].ent <= in_entry_index;
      dv_r[0].gd  <= {in_grad_y, in_grad_x};
      dv_r[0].rx  <= 13'd0;
      dv_r[0].ry  <= 13'd0;
      dv_r[0].nx  <= {in_pixel_x, {FRAC_BITS{1'b0}}};
      dv_r[0].ny  <= {in_pixel_y, {FRAC_BITS{1'b0}}};
      for (int s = 0; s < DIV_STEPS; s++) dv_r[s+1] <= div_step(dv_r[s], grid_eff);
      md_r[0].vld   <= dv_r[DIV_STEPS].vld;
      md_r[0].op    <= dv_r[DIV_STEPS].op;
      md_r[0].ent   <= dv_r[DIV_STEPS].ent;
      md_r[0].gd    <= dv_r[DIV_STEPS].gd;
      md_r[0].fx    <= dv_r[DIV_STEPS].nx[FRAC_BITS-1:0];
      md_r[0].fy    <= dv_r[DIV_STEPS].ny[FRAC_BITS-1:0];
      md_r[0].mr    <= '0;
      md_r[0].mn[0] <= {1'b0, cx}  + {1'b0, pc};
      md_r[0].mn[1] <= {1'b0, cx1} + {1'b0, pc};
      md_r[0].mn[2] <= {1'b0, cx}  + {1'b0, pc1};
      md_r[0].mn[3] <= {1'b0, cx1} + {1'b0, pc1};
      for (int s = 0; s < MOD_STEPS; s++) md_r[s+1] <= mod_step(md_r[s], mod_eff);
    end
  end

  // Table stage: writes and reads meet here in item order, so no forwarding is needed
  assign gwe = en && md_r[MOD_STEPS].vld && (md_r[MOD_STEPS].op == OP_WRITE) &&
               ({1'b0, md_r[MOD_STEPS].ent} < 10'(TABLE_DEPTH));
  assign gw  = md_r[MOD_STEPS].gd;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (gwe) gt_mem[k][ADDR_W'(md_r[MOD_STEPS].ent)] <= gw;
      if (en) rd_r[k] <= gt_mem[k][md_r[MOD_STEPS].mr[k]];
    end
  end

  // Corner offsets (fraction or fraction minus one), fade inner term and fade values
  always_comb begin
    dxs[0] = $signed({1'b0, q1_f_r[0]});
    dxs[1] = $signed({1'b1, q1_f_r[0]});
    dxs[2] = $signed({1'b0, q1_f_r[0]});
    dxs[3] = $signed({1'b1, q1_f_r[0]});
    dys[0] = $signed({1'b0, q1_f_r[1]});
    dys[1] = $signed({1'b0, q1_f_r[1]});
    dys[2] = $signed({1'b1, q1_f_r[1]});
    dys[3] = $signed({1'b1, q1_f_r[1]});
    for (int j = 0; j < 2; j++) begin
      inner[j] = 21'sd6 * $signed({5'd0, q1_f_r[j]}) - 21'sd983040;
    end
    ex4 = f4_r[0][33:16];
    ey4 = f4_r[1][33:16];
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
      q2_vld_r <= 1'b0;
      q3_vld_r <= 1'b0;
      q4_vld_r <= 1'b0;
      q5_vld_r <= 1'b0;
      q6_vld_r <= 1'b0;
      q7_vld_r <= 1'b0;
    end else if (en) begin
      q1_vld_r <= md_r[MOD_STEPS].vld && (md_r[MOD_STEPS].op == OP_PIXEL);
      q2_vld_r <= q1_vld_r;
      q3_vld_r <= q2_vld_r;
      q4_vld_r <= q3_vld_r;
      q5_vld_r <= q4_vld_r;
      q6_vld_r <= q5_vld_r;
      q7_vld_r <= q6_vld_r;
    end
  end

  // Dot products, fade and blend datapath
  always_ff @(posedge clk) begin
    if (en) begin
      q1_f_r[0] <= md_r[MOD_STEPS].fx;
      q1_f_r[1] <= md_r[MOD_STEPS].fy;
      for (int k = 0; k < 4; k++) begin
        pa_r[k] <= $signed(rd_r[k][15:0])  * dxs[k];
        pb_r[k] <= $signed(rd_r[k][31:16]) * dys[k];
      end
      for (int j = 0; j < 2; j++) begin
        f1_r[j]   <= $signed({1'b0, q1_f_r[j]}) * inner[j];
        f2_r[j]   <= q1_f_r[j] * q1_f_r[j];
        q2_f_r[j] <= q1_f_r[j];
      end
      for (int k = 0; k < 4; k++) begin
        dot_r[k] <= 18'((34'(pa_r[k]) + 34'(pb_r[k])) >>> FRAC_BITS);
      end
      for (int j = 0; j < 2; j++) begin
        poly_r[j] <= f1_r[j][37:16] + 22'sd655360;
        f3_r[j]   <= f2_r[j][31:16] * q2_f_r[j];
      end
      dd_r[0]   <= 19'(dot_r[1]) - 19'(dot_r[0]);
      dd_r[1]   <= 19'(dot_r[3]) - 19'(dot_r[2]);
      base_r[0] <= dot_r[0];
      base_r[1] <= dot_r[2];
      for (int j = 0; j < 2; j++) begin
        f4_r[j] <= $signed({1'b0, f3_r[j][31:16]}) * poly_r[j];
      end
      mx_r[0] <= dd_r[0] * ex4;
      mx_r[1] <= dd_r[1] * ex4;
      b5_r    <= base_r;
      ey5_r   <= ey4;
      ab_r[0] <= 22'(b5_r[0]) + 22'($signed(mx_r[0][36:16]));
      ab_r[1] <= 22'(b5_r[1]) + 22'($signed(mx_r[1][36:16]));
      ey6_r   <= ey5_r;
      m7_r    <= (23'(ab_r[1]) - 23'(ab_r[0])) * ey6_r;
      a7_r    <= ab_r[0];
    end
  end

  // Final lerp and saturation
  always_comb begin
    r_full = 26'(a7_r) + 26'($signed(m7_r[40:16]));
    if (r_full > 26'sd32767) begin
      res_val = 16'sh7fff;
    end else if (r_full < -26'sd32768) begin
      res_val = -16'sh8000;
    end else begin
      res_val = r_full[15:0];
    end
    res_vld = q7_vld_r && en;
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (out_vld_r && !out_ready) begin
      if (res_vld) begin
        sk_vld_r <= 1'b1;
        sk_val_r <= res_val;
      end
    end else if (sk_vld_r) begin
      out_vld_r <= 1'b1;
      out_val_r <= sk_val_r;
      sk_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= res_vld;
      out_val_r <= res_val;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_noise_value = out_val_r;

  // Skid holds only behind a waiting result
  `CHK_SAME(a_skid_behind_out, sk_vld_r, out_vld_r)
  // A result arriving at a stalled output lands in the skid register
  `CHK_NEXT(a_skid_catch, out_vld_r && !out_ready && res_vld, sk_vld_r)
  // A taken output drains the skid register
  `CHK_NEXT(a_skid_drain, sk_vld_r && out_ready, !sk_vld_r && out_vld_r)

endmodule
